>>> hw/rtl/cee_pkg.sv
// Shared types and constants for the character escape encoder.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package cee_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CountW = 3;
  localparam int unsigned SeqLen = 4;
  localparam int unsigned RemW = 2;

  localparam logic [CharW-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [CharW-1:0] CH_ZERO = 8'h30;
  localparam logic [CharW-1:0] CH_BS = 8'h08;
  localparam logic [CharW-1:0] CH_FF = 8'h0C;
  localparam logic [CharW-1:0] CH_NL = 8'h0A;
  localparam logic [CharW-1:0] CH_CR = 8'h0D;
  localparam logic [CharW-1:0] CH_TAB = 8'h09;
  localparam logic [CharW-1:0] CH_VT = 8'h0B;
  localparam logic [CharW-1:0] CH_LET_B = 8'h62;
  localparam logic [CharW-1:0] CH_LET_F = 8'h66;
  localparam logic [CharW-1:0] CH_LET_N = 8'h6E;
  localparam logic [CharW-1:0] CH_LET_R = 8'h72;
  localparam logic [CharW-1:0] CH_LET_T = 8'h74;
  localparam logic [CharW-1:0] CH_LET_V = 8'h76;
  localparam logic [CharW-1:0] PRINT_LO = 8'h20;
  localparam logic [CharW-1:0] PRINT_HI = 8'h7E;
  localparam logic [CharW-1:0] LATIN1_EDGE = 8'd160;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DELIM_COUNT  = 3'd0,
    REG_DELIM_CHAR_0 = 3'd1,
    REG_DELIM_CHAR_1 = 3'd2,
    REG_DELIM_CHAR_2 = 3'd3,
    REG_DELIM_CHAR_3 = 3'd4
  } cfg_idx_t;

  // Classification of one input character, handed from the classifier to
  // the serializer.
  typedef struct packed {
    logic [CharW-1:0] chr;
    logic [CharW-1:0] letter;
    logic             escaped;
    logic             printable;
  } cls_t;

endpackage

>>> hw/rtl/cee_if.sv
// Valid/ready channel interfaces for raw characters and escaped bytes.
// Depends on cee_pkg for the character width.
`timescale 1ns / 1ps

interface cee_char_if;
  logic                        valid;
  logic                        ready;
  logic [cee_pkg::CharW-1:0]   in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface cee_esc_if;
  logic                        valid;
  logic                        ready;
  logic [cee_pkg::CharW-1:0]   out_byte;
  logic                        last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

>>> hw/rtl/char_escape_encoder.sv
// Top level of the character escape encoder: configuration registers,
// classifier pipeline and output serializer. Depends on cee_pkg and cee_if.
//
//   channel   dir  handshake      payload
//   char_in   in   valid/ready    in_byte
//   esc_out   out  valid/ready    out_byte, last_byte
//   cfg       in   cfg_we         cfg_index, cfg_data
//
// One escaped byte leaves per cycle while esc_out is ready; a character becomes
// 1 (plain), 2 (backslash and letter) or 4 (octal) bytes, and the single output
// shift register sets the rate. The first byte passes the input register, the
// classification register and the output shift register before it is presented.
// Reset clears all valid bits and the configuration registers to zero.
// A stall on esc_out backs up through the stages without loss or repetition.
`timescale 1ns / 1ps

module char_escape_encoder #(
  parameter int unsigned MAX_DELIMS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  cee_char_if.sink                        char_in,
  cee_esc_if.source                       esc_out,
  input  logic                            cfg_we,
  input  logic [cee_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [cee_pkg::CfgDataW-1:0]    cfg_data
);

  logic [cee_pkg::CountW-1:0] delim_count;
  logic [cee_pkg::CountW-1:0] delim_limit;
  logic [cee_pkg::CharW-1:0]  delim_chars [MAX_DELIMS];
  logic                       cls_valid;
  logic                       cls_take;
  cee_pkg::cls_t              cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_count <= '0;
      for (int i = 0; i < MAX_DELIMS; i++) begin
        delim_chars[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == cee_pkg::REG_DELIM_COUNT) begin
        delim_count <= cfg_data[cee_pkg::CountW-1:0];
      end
      // entries beyond MAX_DELIMS are never consulted, so drop those writes
      for (int i = 0; i < MAX_DELIMS; i++) begin
        if (cfg_index == cee_pkg::CfgIdxW'(cee_pkg::REG_DELIM_CHAR_0 + i)) begin
          delim_chars[i] <= cfg_data[cee_pkg::CharW-1:0];
        end
      end
    end
  end

  // saturate the active count at the number of entries held
  assign delim_limit = (delim_count > cee_pkg::CountW'(MAX_DELIMS)) ?
                       cee_pkg::CountW'(MAX_DELIMS) : delim_count;

  cee_classify #(
    .MAX_DELIMS (MAX_DELIMS)
  ) u_classify (
    .clk         (clk),
    .rst         (rst),
    .char_in     (char_in),
    .delim_chars (delim_chars),
    .delim_limit (delim_limit),
    .cls_valid   (cls_valid),
    .cls         (cls),
    .cls_take    (cls_take)
  );

  cee_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (cls_valid),
    .cls       (cls),
    .cls_take  (cls_take),
    .esc_out   (esc_out)
  );

endmodule

>>> hw/rtl/cee_classify.sv
// Two pipeline stages: input register, then character classification and
// delimiter match. Depends on cee_pkg and cee_if.
`timescale 1ns / 1ps

module cee_classify #(
  parameter int unsigned MAX_DELIMS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  cee_char_if.sink                              char_in,
  input  logic [cee_pkg::CharW-1:0]             delim_chars [MAX_DELIMS],
  input  logic [cee_pkg::CountW-1:0]            delim_limit,
  output logic                                  cls_valid,
  output cee_pkg::cls_t                         cls,
  input  logic                                  cls_take
);

  logic                      v1;
  logic [cee_pkg::CharW-1:0] c1;
  logic                      v2;
  cee_pkg::cls_t             cls2;
  cee_pkg::cls_t             cls_next;
  logic                      s1_ready;
  logic                      s2_ready;
  logic                      match;

  assign s2_ready = !v2 || cls_take;
  assign s1_ready = !v1 || s2_ready;
  assign char_in.ready = s1_ready;
  assign cls_valid = v2;
  assign cls = cls2;

  // Delimiter set lookup; a zero entry or a zero character never matches.
  always_comb begin
    match = 1'b0;
    for (int i = 0; i < MAX_DELIMS; i++) begin
      if (cee_pkg::CountW'(i) < delim_limit && delim_chars[i] != '0 &&
          delim_chars[i] == c1) begin
        match = 1'b1;
      end
    end
  end

  always_comb begin
    cls_next.chr = c1;
    cls_next.printable = (c1 >= cee_pkg::PRINT_LO && c1 <= cee_pkg::PRINT_HI) ||
                         (c1 > cee_pkg::LATIN1_EDGE);
    cls_next.escaped = 1'b1;
    unique case (c1)
      cee_pkg::CH_BS:        cls_next.letter = cee_pkg::CH_LET_B;
      cee_pkg::CH_FF:        cls_next.letter = cee_pkg::CH_LET_F;
      cee_pkg::CH_NL:        cls_next.letter = cee_pkg::CH_LET_N;
      cee_pkg::CH_CR:        cls_next.letter = cee_pkg::CH_LET_R;
      cee_pkg::CH_TAB:       cls_next.letter = cee_pkg::CH_LET_T;
      cee_pkg::CH_VT:        cls_next.letter = cee_pkg::CH_LET_V;
      cee_pkg::CH_BACKSLASH: cls_next.letter = cee_pkg::CH_BACKSLASH;
      default: begin
        cls_next.letter = c1;
        cls_next.escaped = match;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (s2_ready) begin
        v2 <= v1;
      end
      if (s1_ready) begin
        v1 <= char_in.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && char_in.valid) begin
      c1 <= char_in.in_byte;
    end
    if (s2_ready && v1) begin
      cls2 <= cls_next;
    end
  end

endmodule

>>> hw/rtl/cee_serial.sv
// Output stage: builds the 1 to 4 byte escape sequence and shifts it out one
// byte per beat. Depends on cee_pkg and cee_if.
`timescale 1ns / 1ps

module cee_serial (
  input  logic          clk,
  input  logic          rst,
  input  logic          cls_valid,
  input  cee_pkg::cls_t cls,
  output logic          cls_take,
  cee_esc_if.source     esc_out
);

  logic                                busy;
  logic [cee_pkg::RemW-1:0]            rem;
  logic [cee_pkg::CharW-1:0]           sh [cee_pkg::SeqLen];
  logic                                last_beat;
  logic                                load;

  assign last_beat = esc_out.ready && rem == '0;
  assign cls_take = !busy || last_beat;
  assign load = cls_valid && cls_take;

  assign esc_out.valid = busy;
  assign esc_out.out_byte = sh[0];
  assign esc_out.last_byte = rem == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rem <= '0;
    end else if (load) begin
      busy <= 1'b1;
      if (cls.escaped) begin
        rem <= cee_pkg::RemW'(1);
      end else if (cls.printable) begin
        rem <= '0;
      end else begin
        rem <= cee_pkg::RemW'(cee_pkg::SeqLen - 1);
      end
    end else if (busy && esc_out.ready) begin
      if (rem == '0) begin
        busy <= 1'b0;
      end else begin
        rem <= rem - cee_pkg::RemW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (cls.escaped) begin
        sh[0] <= cee_pkg::CH_BACKSLASH;
        sh[1] <= cls.letter;
      end else if (cls.printable) begin
        sh[0] <= cls.chr;
      end else begin
        sh[0] <= cee_pkg::CH_BACKSLASH;
        sh[1] <= cee_pkg::CH_ZERO + {6'b0, cls.chr[7:6]};
        sh[2] <= cee_pkg::CH_ZERO + {5'b0, cls.chr[5:3]};
        sh[3] <= cee_pkg::CH_ZERO + {5'b0, cls.chr[2:0]};
      end
    end else if (busy && esc_out.ready) begin
      // advance to the next byte of the sequence
      for (int i = 0; i < cee_pkg::SeqLen - 1; i++) begin
        sh[i] <= sh[i + 1];
      end
    end
  end

  a_escape_starts_backslash: assert property (@(posedge clk) disable iff (rst)
    load && (cls.escaped || !cls.printable) |=> esc_out.out_byte == cee_pkg::CH_BACKSLASH)
    else $error("escape sequence does not open with a backslash");

  a_plain_single_beat: assert property (@(posedge clk) disable iff (rst)
    load && !cls.escaped && cls.printable |=> busy && esc_out.last_byte &&
                                             $past(cls.chr) == esc_out.out_byte)
    else $error("plain character not emitted as one final beat");

  a_sequence_continues: assert property (@(posedge clk) disable iff (rst)
    esc_out.valid && !esc_out.last_byte |=> esc_out.valid)
    else $error("sequence dropped before its last byte");

  a_no_load_mid_sequence: assert property (@(posedge clk) disable iff (rst)
    busy && rem != '0 |-> !cls_take)
    else $error("new character taken while a sequence is still in flight");

endmodule

>>> test/cee_escape_check.sv
// Watches the character and escaped-byte channels of the escape encoder, predicts
// the escaped bytes of every accepted character and compares them beat by beat.
// Depends on cee_pkg and the channel interfaces in cee_if.
`timescale 1ns / 1ps

module cee_escape_check #(
  parameter int unsigned MAX_DELIMS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  cee_char_if                           char_in,
  cee_esc_if                            esc_out,
  input  logic                          cfg_we,
  input  logic [cee_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [cee_pkg::CfgDataW-1:0]  cfg_data,
  output int unsigned                   error_count,
  output int unsigned                   pending_beats
);

  localparam int unsigned DelimRegs = 4;

  typedef struct packed {
    logic [cee_pkg::CharW-1:0] out_byte;
    logic                      last_byte;
  } esc_beat_t;

  logic [cee_pkg::CountW-1:0] delim_count;
  logic [cee_pkg::CharW-1:0]  delim_chars [DelimRegs];
  esc_beat_t                  expected_beats [$];

  function automatic logic is_delim(input logic [cee_pkg::CharW-1:0] chr);
    int unsigned limit;
    limit = (delim_count > MAX_DELIMS) ? MAX_DELIMS : delim_count;
    if (chr == '0) return 1'b0;
    for (int i = 0; i < limit && i < DelimRegs; i++) begin
      if (delim_chars[i] != '0 && delim_chars[i] == chr) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_escape(input logic [cee_pkg::CharW-1:0] chr);
    logic [cee_pkg::CharW-1:0] letter;
    logic                      escaped;
    escaped = 1'b1;
    case (chr)
      cee_pkg::CH_BS:        letter = cee_pkg::CH_LET_B;
      cee_pkg::CH_FF:        letter = cee_pkg::CH_LET_F;
      cee_pkg::CH_NL:        letter = cee_pkg::CH_LET_N;
      cee_pkg::CH_CR:        letter = cee_pkg::CH_LET_R;
      cee_pkg::CH_TAB:       letter = cee_pkg::CH_LET_T;
      cee_pkg::CH_VT:        letter = cee_pkg::CH_LET_V;
      cee_pkg::CH_BACKSLASH: letter = cee_pkg::CH_BACKSLASH;
      default: begin
        letter = chr;
        escaped = is_delim(chr);
      end
    endcase
    if (escaped) begin
      expected_beats.push_back('{out_byte: cee_pkg::CH_BACKSLASH, last_byte: 1'b0});
      expected_beats.push_back('{out_byte: letter, last_byte: 1'b1});
    end else if ((chr >= cee_pkg::PRINT_LO && chr <= cee_pkg::PRINT_HI) ||
                 chr > cee_pkg::LATIN1_EDGE) begin
      expected_beats.push_back('{out_byte: chr, last_byte: 1'b1});
    end else begin
      // three octal digits, most significant first
      expected_beats.push_back('{out_byte: cee_pkg::CH_BACKSLASH, last_byte: 1'b0});
      expected_beats.push_back('{out_byte: cee_pkg::CH_ZERO + {6'd0, chr[7:6]},
                                 last_byte: 1'b0});
      expected_beats.push_back('{out_byte: cee_pkg::CH_ZERO + {5'd0, chr[5:3]},
                                 last_byte: 1'b0});
      expected_beats.push_back('{out_byte: cee_pkg::CH_ZERO + {5'd0, chr[2:0]},
                                 last_byte: 1'b1});
    end
  endfunction

  always @(posedge clk) begin
    esc_beat_t want;
    if (rst) begin
      delim_count = '0;
      for (int i = 0; i < DelimRegs; i++) delim_chars[i] = '0;
      expected_beats.delete();
      error_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == cee_pkg::REG_DELIM_COUNT) begin
          delim_count = cfg_data[cee_pkg::CountW-1:0];
        end else if (cfg_index >= cee_pkg::REG_DELIM_CHAR_0 &&
                     cfg_index <= cee_pkg::REG_DELIM_CHAR_3) begin
          delim_chars[cfg_index - cee_pkg::REG_DELIM_CHAR_0] =
              cfg_data[cee_pkg::CharW-1:0];
        end
      end
      if (char_in.valid && char_in.ready) predict_escape(char_in.in_byte);
      if (esc_out.valid && esc_out.ready) begin
        if (expected_beats.size() == 0) begin
          $error("out_byte: expected no beat, got 8'h%02h (last_byte %0b)",
                 esc_out.out_byte, esc_out.last_byte);
          error_count++;
        end else begin
          want = expected_beats.pop_front();
          if (esc_out.out_byte !== want.out_byte) begin
            $error("out_byte: expected 8'h%02h, got 8'h%02h", want.out_byte, esc_out.out_byte);
            error_count++;
          end
          if (esc_out.last_byte !== want.last_byte) begin
            $error("last_byte: expected %0b, got %0b", want.last_byte, esc_out.last_byte);
            error_count++;
          end
        end
      end
    end
    pending_beats = expected_beats.size();
  end

endmodule

>>> test/char_escape_encoder_test.sv
// Top of the escape encoder testbench: clock, reset, register writes and
// character stimulus with random idling on both channels; checking is done in
// cee_escape_check. Depends on cee_pkg, cee_if and the encoder RTL.
`timescale 1ns / 1ps

module char_escape_encoder_test;

  localparam int unsigned MaxDelims = 4;
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned PhaseChars = 50;
  localparam int unsigned SettleCycles = 8;
  localparam logic [cee_pkg::CfgIdxW-1:0] RegIdxUnused =
      cee_pkg::CfgIdxW'(int'(cee_pkg::REG_DELIM_CHAR_3) + 1);
  localparam logic [cee_pkg::CfgIdxW-1:0] RegIdxTop = '1;
  localparam logic [cee_pkg::CountW-1:0] CountSaturated = '1;

  localparam logic [cee_pkg::CharW-1:0] ProbeChars [20] = '{
    8'h00, cee_pkg::CH_BS, cee_pkg::CH_FF, cee_pkg::CH_NL, cee_pkg::CH_CR,
    cee_pkg::CH_TAB, cee_pkg::CH_VT, cee_pkg::CH_BACKSLASH, 8'h22, 8'h01,
    cee_pkg::PRINT_LO, cee_pkg::PRINT_HI, 8'h7F, 8'h1F, cee_pkg::LATIN1_EDGE,
    8'hA1, 8'hFF, 8'h80, 8'h41, 8'h27
  };
  localparam logic [cee_pkg::CharW-1:0] ProbeDelims [MaxDelims] =
      '{8'h22, 8'h00, cee_pkg::CH_NL, 8'h01};
  localparam logic [cee_pkg::CharW-1:0] EdgeDelims [MaxDelims] =
      '{cee_pkg::CH_BACKSLASH, cee_pkg::CH_BS, 8'hFF, cee_pkg::PRINT_LO};

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [cee_pkg::CfgIdxW-1:0]  cfg_index;
  logic [cee_pkg::CfgDataW-1:0] cfg_data;
  logic                         in_steady = 1'b0;
  logic                         out_steady = 1'b0;
  logic                         out_ready = 1'b0;
  int unsigned                  ready_hold = 0;
  int unsigned                  errors;
  int unsigned                  pending;
  logic [cee_pkg::CharW-1:0]    delims [MaxDelims];
  logic [cee_pkg::CharW-1:0]    phase_delims [MaxDelims];

  cee_char_if char_in ();
  cee_esc_if  esc_out ();

  assign esc_out.ready = out_ready;

  char_escape_encoder #(.MAX_DELIMS(MaxDelims)) DUT (
    .clk(clk),
    .rst(rst),
    .char_in(char_in),
    .esc_out(esc_out),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cee_escape_check #(.MAX_DELIMS(MaxDelims)) u_escape_check (
    .clk(clk),
    .rst(rst),
    .char_in(char_in),
    .esc_out(esc_out),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .error_count(errors),
    .pending_beats(pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
  endfunction

  function automatic logic [cee_pkg::CharW-1:0] special_char();
    case ($urandom_range(0, 7))
      0: return cee_pkg::CH_BS;
      1: return cee_pkg::CH_FF;
      2: return cee_pkg::CH_NL;
      3: return cee_pkg::CH_CR;
      4: return cee_pkg::CH_TAB;
      5: return cee_pkg::CH_VT;
      6: return cee_pkg::CH_BACKSLASH;
      default: return cee_pkg::LATIN1_EDGE;
    endcase
  endfunction

  function automatic logic [cee_pkg::CharW-1:0] pick_char();
    case ($urandom_range(0, 7))
      0, 1: return delims[$urandom_range(0, MaxDelims - 1)];
      2: return special_char();
      default: return cee_pkg::CharW'($urandom);
    endcase
  endfunction

  function automatic logic [cee_pkg::CharW-1:0] pick_delim();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return special_char();
      2: return '1;
      default: return cee_pkg::CharW'($urandom);
    endcase
  endfunction

  // Output side: hold ready high or low for random stretches.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_steady || $urandom_range(0, 2) != 0) begin
      out_ready <= 1'b1;
      ready_hold <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b0;
      ready_hold <= pick_gap();
    end
  end

  task automatic send_char(input logic [cee_pkg::CharW-1:0] chr);
    char_in.valid <= 1'b1;
    char_in.in_byte <= chr;
    do @(posedge clk); while (!char_in.ready);
    if (!in_steady && $urandom_range(0, 3) == 0) begin
      char_in.valid <= 1'b0;
      repeat (pick_gap() + 1) @(posedge clk);
    end
  endtask

  // Hold off the sender until every escaped byte has left the block.
  task automatic drain();
    char_in.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic configure(input logic [cee_pkg::CountW-1:0] count,
                           input logic [cee_pkg::CharW-1:0] chars [MaxDelims]);
    logic [cee_pkg::CfgDataW-cee_pkg::CountW-1:0] pad;
    logic [cee_pkg::CfgIdxW-1:0]                  junk_idx;
    pad = ($urandom_range(0, 1) == 0) ? '0 :
          (cee_pkg::CfgDataW - cee_pkg::CountW)'($urandom);
    junk_idx = cee_pkg::CfgIdxW'($urandom_range(RegIdxUnused, RegIdxTop));
    delims = chars;
    cfg_we <= 1'b1;
    cfg_index <= cee_pkg::REG_DELIM_COUNT;
    cfg_data <= {pad, count};
    @(posedge clk);
    for (int i = 0; i < MaxDelims; i++) begin
      cfg_index <= cee_pkg::CfgIdxW'(int'(cee_pkg::REG_DELIM_CHAR_0) + i);
      cfg_data <= chars[i];
      @(posedge clk);
    end
    // writes to unused indexes must be dropped
    cfg_index <= junk_idx;
    cfg_data <= cee_pkg::CfgDataW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [cee_pkg::CountW-1:0] count;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= cee_pkg::REG_DELIM_COUNT;
    cfg_data <= '0;
    char_in.valid <= 1'b0;
    char_in.in_byte <= '0;
    for (int i = 0; i < MaxDelims; i++) delims[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration: no delimiters active
    send_char(8'h22);
    send_char(8'h00);
    drain();

    configure(CountSaturated, ProbeDelims);
    foreach (ProbeChars[i]) send_char(ProbeChars[i]);
    drain();

    configure(cee_pkg::CountW'(MaxDelims), EdgeDelims);
    foreach (EdgeDelims[i]) send_char(EdgeDelims[i]);
    send_char(8'h00);

    for (int p = 0; p < RandomPhases; p++) begin
      drain();
      case (p)
        0: count = '0;
        1: count = cee_pkg::CountW'(MaxDelims);
        2: count = CountSaturated;
        default: count = cee_pkg::CountW'($urandom_range(0, 7));
      endcase
      for (int i = 0; i < MaxDelims; i++) phase_delims[i] = pick_delim();
      configure(count, phase_delims);
      in_steady <= (p == 2);
      out_steady <= (p == 2);
      repeat (PhaseChars) send_char(pick_char());
    end

    char_in.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[char_escape_encoder] OK");
    end else begin
      $display("[char_escape_encoder] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[char_escape_encoder] ERROR");
    $finish;
  end

endmodule

>>> char_escape_encoder.f
hw/rtl/cee_pkg.sv
hw/rtl/cee_if.sv
hw/rtl/cee_classify.sv
hw/rtl/cee_serial.sv
hw/rtl/char_escape_encoder.sv
test/cee_escape_check.sv
test/char_escape_encoder_test.sv
